[rtl/core/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Slot geometry, command and status codes, table entry layout, the compare
// result bundle and the generation bump rule.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = IDX_W + 1;
    localparam int KEY_W  = 32;
    localparam int GEN_W  = 8;
    localparam int HIDX_W = 6;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int ENT_W  = KEY_W + GEN_W;

    localparam logic [GEN_W-1:0] GEN_MAX  = '1;
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 3'd0,
        CMD_DEL_KEY    = 3'd1,
        CMD_DEL_HANDLE = 3'd2,
        CMD_LOOKUP     = 3'd3,
        CMD_FIND       = 3'd4
    } ght_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_NULL = 2'd3
    } ght_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HREAD,
        ST_HCHK,
        ST_EXEC,
        ST_RESP
    } ght_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [GEN_W-1:0] gen;
    } ght_entry_t;

    typedef struct packed {
        logic hit;      // key matches a live slot
        logic free;     // slot never used or key null
        logic gen_eq;   // slot generation equals the probe generation
        logic key_null; // slot key is null
    } ght_cmp_t;

    // 255 wraps to 1, never to 0
    function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
        return (g == GEN_MAX) ? GEN_W'(1) : g + GEN_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] to_slot(input logic [HIDX_W-1:0] i);
        return IDX_W'(i);
    endfunction

    function automatic logic [HIDX_W-1:0] to_hidx(input logic [IDX_W-1:0] s);
        return HIDX_W'(s);
    endfunction

    function automatic logic in_range(input logic [HIDX_W-1:0] i);
        return 32'(i) < 32'(SLOTS);
    endfunction

endpackage

[rtl/core/ght_ram.sv]
// ----------------------------------------------------------------------------
// ght_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ght_match.sv]
// ----------------------------------------------------------------------------
// ght_match: slot compare unit
// Compares one table entry against the probe key and generation; shared by
// the key scan, the free-slot search and the handle checks.
// ----------------------------------------------------------------------------
module ght_match (
    input  ght_pkg::ght_entry_t       ent,
    input  logic [ght_pkg::KEY_W-1:0] probe_key,
    input  logic [ght_pkg::GEN_W-1:0] probe_gen,
    output ght_pkg::ght_cmp_t         cmp
);

    logic key_eq;
    logic gen_zero;

    assign key_eq   = (ent.key == probe_key);
    assign gen_zero = (ent.gen == '0);

    always_comb begin
        cmp.key_null = (ent.key == '0);
        cmp.hit      = key_eq && !gen_zero;
        cmp.free     = gen_zero || cmp.key_null;
        cmp.gen_eq   = (ent.gen == probe_gen);
    end

endmodule

[rtl/core/generational_handle_table.sv]
// ----------------------------------------------------------------------------
// generational_handle_table: slot map handing out index/generation handles
// Add, remove, lookup and find over a 64-slot key/generation table, driven
// by a small sequencer around one compare unit and one table RAM.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  cmd, obj_key, in_index, in_generation
//   m_       out        m_valid / m_ready  status, out_index, out_generation, out_key
//
// Add, remove by key and find walk the table one slot per cycle through the
// single RAM read port. Remove by handle and lookup read the addressed slot
// (HREAD, HCHK); remove then writes it in EXEC. Null keys, bad handles and
// unused codes go straight to the response.
// Reset clears all slots at once through per-slot valid bits; no sweep.
// s_ready is high only while the sequencer is idle; a result held in the
// output register does not block the next beat until the next one is done.
// ----------------------------------------------------------------------------
module generational_handle_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ght_pkg::CMD_W-1:0]    s_cmd,
    input  logic [ght_pkg::KEY_W-1:0]    s_obj_key,
    input  logic [ght_pkg::HIDX_W-1:0]   s_in_index,
    input  logic [ght_pkg::GEN_W-1:0]    s_in_generation,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ght_pkg::STAT_W-1:0]   m_status,
    output logic [ght_pkg::HIDX_W-1:0]   m_out_index,
    output logic [ght_pkg::GEN_W-1:0]    m_out_generation,
    output logic [ght_pkg::KEY_W-1:0]    m_out_key
);

    ght_pkg::ght_state_t state_reg, state_next;

    logic [ght_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ght_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [ght_pkg::GEN_W-1:0]  hgen_reg, hgen_next;
    logic [ght_pkg::IDX_W-1:0]  hidx_reg, hidx_next;
    logic [ght_pkg::PTR_W-1:0]  ptr_reg, ptr_next;
    logic [ght_pkg::IDX_W-1:0]  chk_reg;
    logic                       chk_vld_reg;
    logic                       free_vld_reg, free_vld_next;
    logic [ght_pkg::IDX_W-1:0]  free_reg, free_next;
    logic [ght_pkg::GEN_W-1:0]  free_gen_reg, free_gen_next;
    logic [ght_pkg::IDX_W-1:0]  tgt_reg, tgt_next;
    logic [ght_pkg::GEN_W-1:0]  tgt_gen_reg, tgt_gen_next;

    logic [ght_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [ght_pkg::HIDX_W-1:0] res_index_reg, res_index_next;
    logic [ght_pkg::GEN_W-1:0]  res_gen_reg, res_gen_next;
    logic [ght_pkg::KEY_W-1:0]  res_key_reg, res_key_next;

    logic                       m_valid_reg, m_valid_next;
    logic [ght_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic [ght_pkg::HIDX_W-1:0] m_index_reg, m_index_next;
    logic [ght_pkg::GEN_W-1:0]  m_gen_reg, m_gen_next;
    logic [ght_pkg::KEY_W-1:0]  m_key_reg, m_key_next;

    logic [ght_pkg::SLOTS-1:0]  slot_vld_reg;
    logic                       rd_vld_reg;

    logic [ght_pkg::IDX_W-1:0]  rd_addr;
    ght_pkg::ght_entry_t        rd_data;
    ght_pkg::ght_entry_t        cur;
    logic                       ram_we;
    ght_pkg::ght_entry_t        ram_wdata;
    ght_pkg::ght_cmp_t          cmp;
    logic                       scan_more;
    logic [ght_pkg::GEN_W-1:0]  new_gen;

    ght_ram #(
        .WIDTH (ght_pkg::ENT_W),
        .DEPTH (ght_pkg::SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tgt_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // a slot not written since reset reads as null key, generation zero
    assign cur = rd_vld_reg ? rd_data : '0;

    ght_match u_match (
        .ent       (cur),
        .probe_key (key_reg),
        .probe_gen (hgen_reg),
        .cmp       (cmp)
    );

    assign scan_more = (ptr_reg != ght_pkg::PTR_W'(ght_pkg::SLOTS));
    assign rd_addr   = (state_reg == ght_pkg::ST_SCAN) ? ptr_reg[ght_pkg::IDX_W-1:0]
                                                       : hidx_reg;
    assign new_gen   = ght_pkg::bump_gen(tgt_gen_reg);
    assign s_ready   = (state_reg == ght_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ght_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            slot_vld_reg <= '0;
            chk_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            chk_vld_reg <= (state_reg == ght_pkg::ST_SCAN) && scan_more;
            if (ram_we) begin
                slot_vld_reg[tgt_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        hgen_reg       <= hgen_next;
        hidx_reg       <= hidx_next;
        ptr_reg        <= ptr_next;
        chk_reg        <= ptr_reg[ght_pkg::IDX_W-1:0];
        rd_vld_reg     <= slot_vld_reg[rd_addr];
        free_vld_reg   <= free_vld_next;
        free_reg       <= free_next;
        free_gen_reg   <= free_gen_next;
        tgt_reg        <= tgt_next;
        tgt_gen_reg    <= tgt_gen_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_gen_reg    <= res_gen_next;
        res_key_reg    <= res_key_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_gen_reg      <= m_gen_next;
        m_key_reg      <= m_key_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        hgen_next       = hgen_reg;
        hidx_next       = hidx_reg;
        ptr_next        = ptr_reg;
        free_vld_next   = free_vld_reg;
        free_next       = free_reg;
        free_gen_next   = free_gen_reg;
        tgt_next        = tgt_reg;
        tgt_gen_next    = tgt_gen_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_gen_next    = res_gen_reg;
        res_key_next    = res_key_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_gen_next      = m_gen_reg;
        m_key_next      = m_key_reg;
        ram_we          = 1'b0;
        ram_wdata.key   = key_reg;
        ram_wdata.gen   = new_gen;

        case (state_reg)
            ght_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_cmd;
                    key_next        = s_obj_key;
                    hgen_next       = s_in_generation;
                    hidx_next       = ght_pkg::to_slot(s_in_index);
                    ptr_next        = '0;
                    free_vld_next   = 1'b0;
                    res_status_next = ght_pkg::STAT_MISS;
                    res_index_next  = '0;
                    res_gen_next    = '0;
                    res_key_next    = '0;
                    state_next      = ght_pkg::ST_RESP;
                    if (s_cmd inside {ght_pkg::CMD_ADD, ght_pkg::CMD_DEL_KEY,
                                      ght_pkg::CMD_FIND}) begin
                        if (s_obj_key == '0) begin
                            res_status_next = ght_pkg::STAT_NULL;
                        end else begin
                            state_next = ght_pkg::ST_SCAN;
                        end
                    end else if (s_cmd inside {ght_pkg::CMD_DEL_HANDLE,
                                               ght_pkg::CMD_LOOKUP}) begin
                        if (s_in_generation != '0 && ght_pkg::in_range(s_in_index)) begin
                            state_next = ght_pkg::ST_HREAD;
                        end
                    end
                end
            end

            ght_pkg::ST_SCAN: begin
                if (scan_more) begin
                    ptr_next = ptr_reg + ght_pkg::PTR_W'(1);
                end
                if (chk_vld_reg) begin
                    if (cmp.hit) begin
                        tgt_next     = chk_reg;
                        tgt_gen_next = cur.gen;
                        state_next   = ght_pkg::ST_EXEC;
                    end else begin
                        // remember the first free slot for add
                        if (cmp.free && !free_vld_reg) begin
                            free_vld_next = 1'b1;
                            free_next     = chk_reg;
                            free_gen_next = cur.gen;
                        end
                        if (chk_reg == ght_pkg::SLOT_LAST) begin
                            state_next = ght_pkg::ST_RESP;
                            if (cmd_reg == ght_pkg::CMD_ADD) begin
                                if (free_vld_reg) begin
                                    tgt_next     = free_reg;
                                    tgt_gen_next = free_gen_reg;
                                    state_next   = ght_pkg::ST_EXEC;
                                end else if (cmp.free) begin
                                    tgt_next     = chk_reg;
                                    tgt_gen_next = cur.gen;
                                    state_next   = ght_pkg::ST_EXEC;
                                end else begin
                                    res_status_next = ght_pkg::STAT_FULL;
                                end
                            end
                        end
                    end
                end
            end

            ght_pkg::ST_HREAD: begin
                state_next = ght_pkg::ST_HCHK;
            end

            ght_pkg::ST_HCHK: begin
                if (cmd_reg == ght_pkg::CMD_DEL_HANDLE) begin
                    tgt_next     = hidx_reg;
                    tgt_gen_next = cur.gen;
                    state_next   = ght_pkg::ST_EXEC;
                end else begin
                    if (cmp.gen_eq && !cmp.key_null) begin
                        res_status_next = ght_pkg::STAT_OK;
                        res_index_next  = ght_pkg::to_hidx(hidx_reg);
                        res_gen_next    = hgen_reg;
                        res_key_next    = cur.key;
                    end
                    state_next = ght_pkg::ST_RESP;
                end
            end

            ght_pkg::ST_EXEC: begin
                res_status_next = ght_pkg::STAT_OK;
                res_index_next  = ght_pkg::to_hidx(tgt_reg);
                res_key_next    = '0;
                if (cmd_reg == ght_pkg::CMD_FIND) begin
                    res_gen_next = tgt_gen_reg;
                end else begin
                    // add keeps the key, both removes drop it
                    ram_we        = 1'b1;
                    ram_wdata.key = (cmd_reg == ght_pkg::CMD_ADD) ? key_reg : '0;
                    res_gen_next  = new_gen;
                end
                state_next = ght_pkg::ST_RESP;
            end

            ght_pkg::ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_gen_next    = res_gen_reg;
                    m_key_next    = res_key_reg;
                    state_next    = ght_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ght_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_out_index      = m_index_reg;
    assign m_out_generation = m_gen_reg;
    assign m_out_key        = m_key_reg;

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ght_pkg::STAT_OK) |->
            (m_out_index == '0 && m_out_generation == '0 && m_out_key == '0))
        else $error("failed result carries a nonzero handle or key");

    a_ok_gen_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ght_pkg::STAT_OK) |-> (m_out_generation != '0))
        else $error("successful result with generation zero");

    a_write_gen_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (ram_wdata.gen != '0))
        else $error("slot written with generation zero");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ght_pkg::ST_IDLE))
        else $error("sequencer idle right after an accepted beat");

endmodule
